FILE: rtl/core/uvcifp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvcifp_pkg
// Shared codes, constants and helpers for the UVC isochronous frame packetizer.
// ----------------------------------------------------------------------------
package uvcifp_pkg;

  localparam int OFFSET_BITS_DEF = 26;

  // Input operation codes.
  localparam logic [1:0] OP_SET_IFACE  = 2'd0;
  localparam logic [1:0] OP_SOF        = 2'd1;
  localparam logic [1:0] OP_IN_DONE    = 2'd2;
  localparam logic [1:0] OP_BUF_FILLED = 2'd3;

  // Play state codes, also reported on the play mode output.
  localparam logic [1:0] PS_STOP   = 2'd0;
  localparam logic [1:0] PS_READY  = 2'd1;
  localparam logic [1:0] PS_STREAM = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ISO_EP    = 2'd0;
  localparam logic [1:0] REG_FULL_CNT  = 2'd1;
  localparam logic [1:0] REG_LAST_LEN  = 2'd2;
  localparam logic [1:0] REG_SLICE_LEN = 2'd3;

  localparam logic [9:0] MAX_PAYLOAD = 10'd1022;

  // Header flag byte bits.
  localparam int HDR_FID = 0;
  localparam int HDR_EOF = 1;

  // Lengths above the largest payload are clamped to it.
  function automatic logic [9:0] sat_payload(input logic [9:0] v);
    sat_payload = (v > MAX_PAYLOAD) ? MAX_PAYLOAD : v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/uvc_iso_frame_packetizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvc_iso_frame_packetizer
// Cuts double-buffered video frames into isochronous packet descriptors.
// ----------------------------------------------------------------------------
// Every input transfer produces exactly one result transfer. A set-interface
// item selects stop (alternate 0) or ready (alternate 1); any other alternate
// is rejected with stall_res and changes nothing. In ready, a start of frame
// sends a header-only descriptor and enters streaming. While streaming, each
// in-complete on the configured endpoint sends the next slice of the frame:
// full_packet_count slices of slice_bytes, then one final slice of
// last_payload_bytes that sets end of frame and swaps to the other buffer if
// the producer has marked it full. The block sustains one item per clock
// while the output is not stalled: an item is captured in an input register,
// and the state update plus the result computation (a few compares and one
// offset add) happen in the single cycle in which it moves into the output
// register. Both registers lie between an input transfer and out_valid. When
// the output is stalled the input register holds one further item before
// in_stall rises. The user must write configuration registers over the
// APB-style port only while the block is idle; the block does not enforce it.
module uvc_iso_frame_packetizer #(
  parameter int OFFSET_BITS = uvcifp_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [3:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic      [31:0]            prdata,
  output logic                        pready,
  // Input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_op,
  input  wire logic [15:0]            in_alt_value,
  input  wire logic [6:0]             in_endpoint,
  input  wire logic                   in_filled_buffer,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        out_send,
  output logic [7:0]                  out_header_flags,
  output logic                        out_buffer_select,
  output logic [OFFSET_BITS-1:0]      out_payload_offset,
  output logic [9:0]                  out_payload_bytes,
  output logic                        out_stall_res,
  output logic [1:0]                  out_play_mode
);
  import uvcifp_pkg::*;

  // Configuration registers.
  logic [3:0]  iso_ep_r;
  logic [15:0] full_cnt_r;
  logic [9:0]  last_len_r;
  logic [9:0]  slice_len_r;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_ep_r    <= 4'd1;
      full_cnt_r  <= 16'd0;
      last_len_r  <= 10'd0;
      slice_len_r <= MAX_PAYLOAD;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ISO_EP:    iso_ep_r    <= pwdata[3:0];
        REG_FULL_CNT:  full_cnt_r  <= pwdata[15:0];
        REG_LAST_LEN:  last_len_r  <= pwdata[9:0];
        REG_SLICE_LEN: slice_len_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ISO_EP:    prdata = {28'd0, iso_ep_r};
      REG_FULL_CNT:  prdata = {16'd0, full_cnt_r};
      REG_LAST_LEN:  prdata = {22'd0, last_len_r};
      REG_SLICE_LEN: prdata = {22'd0, slice_len_r};
      default:       prdata = 32'd0;
    endcase
  end

  // Input register stage.
  logic        in_vld_r;
  logic [1:0]  op_r;
  logic [15:0] alt_r;
  logic [6:0]  ep_r;
  logic        fb_r;

  // The output register takes a new result when it is empty or being drained.
  logic        advance;
  logic        out_vld_r;

  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid & ~in_stall) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & ~in_stall) begin
      op_r  <= in_op;
      alt_r <= in_alt_value;
      ep_r  <= in_endpoint;
      fb_r  <= in_filled_buffer;
    end
  end

  // Packetizer state.
  logic [1:0]             play_r,  play_nxt;
  logic [15:0]            idx_r,   idx_nxt;
  logic [OFFSET_BITS-1:0] offs_r,  offs_nxt;
  logic [1:0]             hdr_r,   hdr_nxt;     // end of frame and frame id
  logic                   cur_r,   cur_nxt;
  logic [1:0]             full_r,  full_nxt;

  // Result of the item being retired.
  logic                   send_c;
  logic [1:0]             flags_c;
  logic                   bsel_c;
  logic [OFFSET_BITS-1:0] poffs_c;
  logic [9:0]             bytes_c;
  logic                   stall_c;

  logic [1:0]             hdr_tmp;
  logic [9:0]             slice_sat;
  logic [9:0]             last_sat;

  assign slice_sat = sat_payload(slice_len_r);
  assign last_sat  = sat_payload(last_len_r);

  always_comb begin
    play_nxt = play_r;
    idx_nxt  = idx_r;
    offs_nxt = offs_r;
    hdr_nxt  = hdr_r;
    cur_nxt  = cur_r;
    full_nxt = full_r;
    send_c   = 1'b0;
    flags_c  = 2'b00;
    bsel_c   = 1'b0;
    poffs_c  = '0;
    bytes_c  = 10'd0;
    stall_c  = 1'b0;
    hdr_tmp  = hdr_r;
    case (op_r)
      OP_SET_IFACE: begin
        if (alt_r == 16'd0) begin
          play_nxt = PS_STOP;
        end else if (alt_r == 16'd1) begin
          play_nxt = PS_READY;
        end else begin
          stall_c = 1'b1;
        end
      end
      OP_SOF: begin
        if (play_r == PS_READY) begin
          // An empty current buffer means the producer filled the other one.
          cur_nxt  = full_r[cur_r] ? cur_r : ~cur_r;
          idx_nxt  = 16'd0;
          offs_nxt = '0;
          play_nxt = PS_STREAM;
          send_c   = 1'b1;
          flags_c  = hdr_r;
          bsel_c   = cur_nxt;
        end
      end
      OP_IN_DONE: begin
        if ((ep_r == {3'd0, iso_ep_r}) && (play_r == PS_STREAM)) begin
          if (idx_r == 16'd0) begin
            hdr_tmp[HDR_EOF] = 1'b0;
            hdr_tmp[HDR_FID] = ~hdr_r[HDR_FID];
          end
          send_c  = 1'b1;
          bsel_c  = cur_r;
          poffs_c = offs_r;
          if (idx_r < full_cnt_r) begin
            bytes_c  = slice_sat;
            idx_nxt  = idx_r + 16'd1;
            offs_nxt = offs_r + OFFSET_BITS'(slice_sat);
          end else begin
            hdr_tmp[HDR_EOF] = 1'b1;
            bytes_c  = last_sat;
            if (full_r[~cur_r]) begin
              full_nxt[cur_r] = 1'b0;
              cur_nxt         = ~cur_r;
            end
            idx_nxt  = 16'd0;
            offs_nxt = '0;
          end
          hdr_nxt = hdr_tmp;
          flags_c = hdr_tmp;
        end
      end
      OP_BUF_FILLED: begin
        full_nxt[fb_r] = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r <= PS_STOP;
      idx_r  <= 16'd0;
      offs_r <= '0;
      hdr_r  <= 2'b00;
      cur_r  <= 1'b0;
      full_r <= 2'b00;
    end else if (advance) begin
      play_r <= play_nxt;
      idx_r  <= idx_nxt;
      offs_r <= offs_nxt;
      hdr_r  <= hdr_nxt;
      cur_r  <= cur_nxt;
      full_r <= full_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (~out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_send           <= send_c;
      out_header_flags   <= {6'd0, flags_c};
      out_buffer_select  <= bsel_c;
      out_payload_offset <= poffs_c;
      out_payload_bytes  <= bytes_c;
      out_stall_res      <= stall_c;
      out_play_mode      <= play_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule
`default_nettype wire

FILE: rtl/core/uvcifp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvcifp_checker
// Port-level checks for the UVC isochronous frame packetizer.
// ----------------------------------------------------------------------------
module uvcifp_checker #(
  parameter int OFFSET_BITS = uvcifp_pkg::OFFSET_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic                   out_send,
  input wire logic [7:0]             out_header_flags,
  input wire logic                   out_buffer_select,
  input wire logic [OFFSET_BITS-1:0] out_payload_offset,
  input wire logic [9:0]             out_payload_bytes,
  input wire logic                   out_stall_res,
  input wire logic [1:0]             out_play_mode
);
  import uvcifp_pkg::*;

  // A result without a packet carries an all-zero descriptor.
  a_idle_desc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_send) |-> (out_header_flags == 8'd0 && !out_buffer_select
      && out_payload_offset == '0 && out_payload_bytes == 10'd0))
    else $error("descriptor fields set without a packet");

  // Packets go out only when streaming, never with a rejected alternate.
  a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send) |-> (out_play_mode == PS_STREAM && !out_stall_res
      && out_payload_bytes <= MAX_PAYLOAD && out_header_flags[7:2] == 6'd0))
    else $error("packet issued outside streaming or malformed");

  // A rejected set interface reports no packet.
  a_stall_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall_res) |-> (out_play_mode != PS_STREAM || !out_send))
    else $error("rejected request reported a packet");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_payload_offset)
      && $stable(out_send)))
    else $error("stalled result changed");

endmodule

bind uvc_iso_frame_packetizer uvcifp_checker #(.OFFSET_BITS(OFFSET_BITS)) u_uvcifp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_send           (out_send),
  .out_header_flags   (out_header_flags),
  .out_buffer_select  (out_buffer_select),
  .out_payload_offset (out_payload_offset),
  .out_payload_bytes  (out_payload_bytes),
  .out_stall_res      (out_stall_res),
  .out_play_mode      (out_play_mode)
);
`default_nettype wire

FILE: bench/uvcifp_descriptor_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uvcifp_descriptor_check
// Watches the packetizer's configuration, input and result channels, predicts
// each packet descriptor and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module uvcifp_descriptor_check #(
  parameter int OFFSET_BITS = uvcifp_pkg::OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  input  logic                   pready,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [1:0]             in_op,
  input  logic [15:0]            in_alt_value,
  input  logic [6:0]             in_endpoint,
  input  logic                   in_filled_buffer,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   out_send,
  input  logic [7:0]             out_header_flags,
  input  logic                   out_buffer_select,
  input  logic [OFFSET_BITS-1:0] out_payload_offset,
  input  logic [9:0]             out_payload_bytes,
  input  logic                   out_stall_res,
  input  logic [1:0]             out_play_mode,
  output int                     mismatches,
  output int                     descriptors_due
);
  import uvcifp_pkg::*;

  typedef struct packed {
    logic                   send;
    logic [7:0]             flags;
    logic                   bsel;
    logic [OFFSET_BITS-1:0] offset;
    logic [9:0]             bytes;
    logic                   stall_res;
    logic [1:0]             mode;
  } descr_t;

  // Mirror of the configuration registers.
  logic [3:0]  iso_ep;
  logic [15:0] full_cnt;
  logic [9:0]  last_len;
  logic [9:0]  slice_len;

  // Mirror of the packetizer state.
  logic [1:0]             play;
  logic                   alt_sel;
  logic [15:0]            slice_idx;
  logic [OFFSET_BITS-1:0] slice_offs;
  logic [7:0]             hdr;
  logic                   cur_buf;
  logic [1:0]             buf_full;

  descr_t due_q[$];

  // Only 1023 lies above the largest payload in a 10-bit length.
  function automatic logic [9:0] clamp_len(input logic [9:0] v);
    return (v == 10'h3FF) ? MAX_PAYLOAD : v;
  endfunction

  task automatic packetize(input logic [1:0] op, input logic [15:0] alt,
                           input logic [6:0] ep, input logic fb, output descr_t d);
    logic cur;
    d = '0;
    case (op)
      OP_SET_IFACE: begin
        if (alt <= 16'd1) begin
          alt_sel = alt[0];
          play = alt[0] ? PS_READY : PS_STOP;
        end else begin
          d.stall_res = 1'b1;
        end
      end
      OP_SOF: begin
        if (play == PS_READY) begin
          if (!buf_full[cur_buf]) cur_buf = ~cur_buf;
          slice_idx = '0;
          slice_offs = '0;
          play = PS_STREAM;
          d.send = 1'b1;
          d.flags = hdr;
          d.bsel = cur_buf;
        end
      end
      OP_IN_DONE: begin
        if (ep == {3'b000, iso_ep} && play == PS_STREAM) begin
          cur = cur_buf;
          // A new frame flips the frame id and drops end of frame.
          if (slice_idx == 16'd0) begin
            hdr[HDR_EOF] = 1'b0;
            hdr[HDR_FID] = ~hdr[HDR_FID];
          end
          d.send = 1'b1;
          d.bsel = cur;
          d.offset = slice_offs;
          if (slice_idx < full_cnt) begin
            d.bytes = clamp_len(slice_len);
            slice_idx = slice_idx + 16'd1;
            slice_offs = slice_offs + d.bytes;
          end else begin
            hdr[HDR_EOF] = 1'b1;
            d.bytes = clamp_len(last_len);
            if (buf_full[~cur]) begin
              buf_full[cur] = 1'b0;
              cur_buf = ~cur;
            end
            slice_idx = '0;
            slice_offs = '0;
          end
          d.flags = hdr;
        end
      end
      default: buf_full[fb] = 1'b1;
    endcase
    d.mode = play;
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
    end
  endtask

  always @(posedge clk) begin
    descr_t want;
    descr_t seen;
    if (!rst_n) begin
      iso_ep = 4'd1;
      full_cnt = '0;
      last_len = '0;
      slice_len = MAX_PAYLOAD;
      play = PS_STOP;
      alt_sel = 1'b0;
      slice_idx = '0;
      slice_offs = '0;
      hdr = '0;
      cur_buf = 1'b0;
      buf_full = '0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ISO_EP:    iso_ep = pwdata[3:0];
          REG_FULL_CNT:  full_cnt = pwdata[15:0];
          REG_LAST_LEN:  last_len = pwdata[9:0];
          REG_SLICE_LEN: slice_len = pwdata[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = '{out_send, out_header_flags, out_buffer_select, out_payload_offset,
                 out_payload_bytes, out_stall_res, out_play_mode};
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: descriptor with none expected, expected nothing, actual 0x%0h",
                   $time, seen);
        end else begin
          want = due_q.pop_front();
          compare_field("send", want.send, seen.send);
          compare_field("header_flags", want.flags, seen.flags);
          compare_field("buffer_select", want.bsel, seen.bsel);
          compare_field("payload_offset", want.offset, seen.offset);
          compare_field("payload_bytes", want.bytes, seen.bytes);
          compare_field("stall_res", want.stall_res, seen.stall_res);
          compare_field("play_mode", want.mode, seen.mode);
        end
      end
      if (in_valid && !in_stall) begin
        packetize(in_op, in_alt_value, in_endpoint, in_filled_buffer, want);
        due_q.push_back(want);
      end
    end
    descriptors_due = due_q.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives USB-side events and register writes into the UVC isochronous frame
// packetizer and gives the verdict from the descriptor checker's count.
// ----------------------------------------------------------------------------
module tb;
  import uvcifp_pkg::*;

  localparam int OFFSET_BITS = OFFSET_BITS_DEF;
  localparam int ITEM_TARGET = 1650;
  // The longest honest quiet stretch is a long stall or gap plus settling, so
  // this limit leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;

  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_op = OP_SET_IFACE;
  logic [15:0]            in_alt_value = '0;
  logic [6:0]             in_endpoint = '0;
  logic                   in_filled_buffer = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_send;
  logic [7:0]             out_header_flags;
  logic                   out_buffer_select;
  logic [OFFSET_BITS-1:0] out_payload_offset;
  logic [9:0]             out_payload_bytes;
  logic                   out_stall_res;
  logic [1:0]             out_play_mode;

  int mismatches;
  int descriptors_due;

  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  // Local copies of the endpoint and frame length, used to aim the in-complete
  // events at the configured endpoint and to size each frame's run of slices.
  logic [3:0]  ep_now = 4'd1;
  logic [15:0] count_now = '0;

  always #1 clk = ~clk;

  uvc_iso_frame_packetizer #(.OFFSET_BITS(OFFSET_BITS)) uut (.*);

  uvcifp_descriptor_check #(.OFFSET_BITS(OFFSET_BITS)) desc_check (.*);

  // The result side stalls in runs: mostly short ones, now and then a long one,
  // and free-running stretches in between. Phases with stalls switched off give
  // long runs of back-to-back transfers.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 35) begin
      out_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end
  end

  // Watchdog: any accepted transfer or register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one event on the input channel and holds it until the transfer
  // happens. Called at a falling edge and returns at a falling edge with valid
  // still high, so that a following event can go out back to back.
  task automatic present(input logic [1:0] op, input logic [15:0] alt,
                         input logic [6:0] ep, input logic fb);
    int gap;
    gap = 0;
    if (gaps_on) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 60) ? 0 : (gap < 92) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_alt_value <= alt;
    in_endpoint <= ep;
    in_filled_buffer <= fb;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops offering events and waits until every predicted descriptor has come
  // out of the two-stage pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (descriptors_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write: a setup phase, then an access phase that completes on
  // pready. A spare idle period at the end keeps psel from dropping and rising
  // in the same step when writes come back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Picks a new setting for some of the registers and for the idling, always
  // with the block drained. Lengths favor the extremes, frame lengths are
  // mostly short so that many frames complete.
  task automatic retune();
    int r;
    logic [9:0] len;
    if ($urandom_range(0, 3) == 0) begin
      ep_now = 4'($urandom_range(0, 15));
      write_reg(REG_ISO_EP, {28'd0, ep_now});
    end
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) count_now = 16'($urandom_range(0, 4));
      else if (r < 90) count_now = 16'($urandom_range(5, 40));
      else if (r < 95) count_now = 16'hFFFF;
      else count_now = 16'($urandom_range(0, 65535));
      write_reg(REG_FULL_CNT, {16'd0, count_now});
    end
    for (int k = 0; k < 2; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 9);
        len = (r == 0) ? 10'd0 : (r == 1) ? 10'd1 : (r == 2) ? MAX_PAYLOAD :
              (r == 3) ? 10'h3FF : 10'($urandom_range(0, 1023));
        write_reg(k == 0 ? REG_LAST_LEN : REG_SLICE_LEN, {22'd0, len});
      end
    end
    gaps_on = ($urandom_range(0, 3) != 0);
    stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  initial begin
    int slices;
    int r;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset configuration: endpoint 1, no full
    // slices, empty final slice, full-size slices.
    present(OP_IN_DONE, 16'h0000, 7'd1, 1'b0);      // stopped, so ignored
    present(OP_SOF, 16'hFFFF, 7'h7F, 1'b1);         // start of frame outside ready
    present(OP_SET_IFACE, 16'hFFFF, 7'h7F, 1'b1);   // unsupported alternate
    present(OP_SET_IFACE, 16'd2, 7'd0, 1'b0);       // smallest unsupported alternate
    present(OP_SET_IFACE, 16'd1, 7'd0, 1'b0);       // ready
    present(OP_SOF, 16'd0, 7'd0, 1'b0);             // current buffer empty: swap
    present(OP_IN_DONE, 16'hFFFF, 7'd1, 1'b1);      // first slice is also the last
    present(OP_IN_DONE, 16'd0, 7'h7F, 1'b0);        // wrong endpoint
    present(OP_BUF_FILLED, 16'd0, 7'd0, 1'b0);
    present(OP_BUF_FILLED, 16'hFFFF, 7'h7F, 1'b1);
    settle();

    // Saturating lengths on the highest endpoint: two full slices and a final
    // one that swaps to the other, full buffer.
    write_reg(REG_ISO_EP, 32'd15);
    write_reg(REG_FULL_CNT, 32'd2);
    write_reg(REG_LAST_LEN, 32'd1023);
    write_reg(REG_SLICE_LEN, 32'd1023);
    repeat (3) present(OP_IN_DONE, 16'd0, 7'd15, 1'b0);
    present(OP_SOF, 16'd0, 7'd0, 1'b0);             // ignored while streaming
    present(OP_IN_DONE, 16'd0, 7'h1F, 1'b0);        // low bits match, still wrong
    present(OP_SET_IFACE, 16'd0, 7'd0, 1'b0);       // stop
    settle();

    // Empty full slices in a frame of the largest length, then the count is
    // lowered below the slice index mid-frame, which forces the final slice.
    write_reg(REG_ISO_EP, 32'd0);
    write_reg(REG_FULL_CNT, 32'd65535);
    write_reg(REG_LAST_LEN, 32'd1);
    write_reg(REG_SLICE_LEN, 32'd0);
    present(OP_SET_IFACE, 16'd1, 7'd0, 1'b0);
    present(OP_SOF, 16'd0, 7'd0, 1'b0);
    repeat (3) present(OP_IN_DONE, 16'd0, 7'd0, 1'b0);
    settle();
    write_reg(REG_FULL_CNT, 32'd1);
    present(OP_IN_DONE, 16'hFFFF, 7'd0, 1'b1);
    ep_now = 4'd0;
    count_now = 16'd1;

    // Random part: mostly well-formed streaming sessions with random content,
    // with stray events and broken sessions mixed in. Each session starts from
    // a drained block, so the sender waits for every result before the next.
    while (items_sent < ITEM_TARGET) begin
      settle();
      retune();
      if ($urandom_range(0, 9) < 8) present(OP_SET_IFACE, 16'd1, 7'($urandom), 1'($urandom));
      repeat ($urandom_range(0, 2))
        present(OP_BUF_FILLED, 16'($urandom), 7'($urandom), 1'($urandom));
      present(OP_SOF, 16'($urandom), 7'($urandom), 1'($urandom));
      slices = (count_now > 16'd12) ? 40 : $urandom_range(1, 3 * (count_now + 1));
      for (int s = 0; s < slices; s++) begin
        r = $urandom_range(0, 99);
        if (r < 75) present(OP_IN_DONE, 16'($urandom), {3'b000, ep_now}, 1'($urandom));
        else if (r < 88) present(OP_BUF_FILLED, 16'($urandom), 7'($urandom), 1'($urandom));
        else if (r < 93) present(OP_SOF, 16'($urandom), 7'($urandom), 1'($urandom));
        else present(2'($urandom), 16'($urandom), 7'($urandom), 1'($urandom));
      end
      // Sometimes the session ends in stop or a rejected alternate; otherwise
      // streaming carries over into the next register setting.
      r = $urandom_range(0, 9);
      if (r < 2) present(OP_SET_IFACE, 16'd0, 7'($urandom), 1'($urandom));
      else if (r < 3) present(OP_SET_IFACE, 16'($urandom_range(2, 65535)), 7'($urandom),
                              1'($urandom));
    end

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
